@@ rtl/pid_controller_step_macros.svh @@
// ----------------------------------------------------------------------------
// PID controller step: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_STEP_MACROS_SVH
`define PID_CONTROLLER_STEP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDC_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// PID controller step: shared package
// Widths, register indexes, microcode codes and beat types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pidc_pkg;

   localparam int DATA_W          = 32;
   localparam int LIMIT_W         = 31;
   localparam int ACC_W           = 64;
   localparam int Q_FRAC_BITS     = 16;
   localparam int INTEG_FRAC_BITS = 32;
   localparam int MUL_W           = DATA_W + 1;
   localparam int PROD_W          = 2 * MUL_W;
   localparam int SUM_W           = DATA_W + 2;
   localparam int I_PROD_SHIFT    = 32 - INTEG_FRAC_BITS;
   localparam int NUM_STEPS       = 7;
   localparam int STEP_W          = $clog2(NUM_STEPS);
   localparam int CSR_INDEX_W     = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P       = 3'd0,
      CSR_GAIN_D       = 3'd1,
      CSR_GAIN_I       = 3'd2,
      CSR_ENABLE       = 3'd3,
      CSR_OUTPUT_LIMIT = 3'd4,
      CSR_Y_MAX        = 3'd5,
      CSR_OPEN_LOOP    = 3'd6
   } csr_index_type;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [2:0] {
      UOP_LATCH,
      UOP_PENDING,
      UOP_SET,
      UOP_INTEG,
      UOP_SUM,
      UOP_UPDATE,
      UOP_PUBLISH
   } uop_type;

   typedef enum logic [1:0] {
      MSEL_NONE,
      MSEL_P,
      MSEL_D,
      MSEL_I
   } msel_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_REQ,
      COND_ROOM
   } cond_type;

   typedef struct packed {
      uop_type  uop;
      msel_type msel;
      logic     fire;
   } ctrl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] error_p;
      logic signed [DATA_W-1:0] error_d;
      logic signed [DATA_W-1:0] feed_forward;
      logic                     integrator_set;
      logic                     integrator_hold;
      logic signed [DATA_W-1:0] integrator_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] control_out;
      logic signed [DATA_W-1:0] integrator_out;
      logic signed [DATA_W-1:0] p_part;
      logic signed [DATA_W-1:0] d_part;
      logic                     limited;
   } rsp_type;

endpackage

@@ rtl/pid_controller_step.sv @@
// ----------------------------------------------------------------------------
// PID controller step with anti-windup
// Steps: latch, pending, set, integ, sum, update and publish, which waits for
// output room. The seven-step microprogram runs the three products through
// one shared 33 x 33 multiplier and takes a new beat only at the latch step.
// Reset clears the state and the step counter and reloads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pid_controller_step_macros.svh"

module pid_controller_step
   import pidc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_wdata
);

   ctrl_type ctrl;
   logic     out_room;

   logic signed [DATA_W-1:0]  gain_p_ff, gain_p_in;
   logic signed [DATA_W-1:0]  gain_d_ff, gain_d_in;
   logic [DATA_W-1:0]         gain_i_ff, gain_i_in;
   logic                      enable_ff, enable_in;
   logic [LIMIT_W-1:0]        out_limit_ff, out_limit_in;
   logic [LIMIT_W-1:0]        y_max_ff, y_max_in;
   logic                      open_loop_ff, open_loop_in;
   logic                      pending_ff, pending_in;

   logic signed [ACC_W-1:0]   accum_ff, accum_in;
   logic signed [DATA_W-1:0]  prev_ff, prev_in;
   logic signed [DATA_W-1:0]  held_ff, held_in;
   logic                      frozen_ff, frozen_in;

   req_type                   req_ff, req_in;
   logic signed [PROD_W-1:0]  mul_ff, mul_in;
   logic signed [DATA_W-1:0]  p_ff, p_in;
   logic signed [DATA_W-1:0]  d_ff, d_in;
   logic signed [DATA_W-1:0]  integ_ff, integ_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [DATA_W-1:0]  yc_ff, yc_in;
   logic                      limited_ff, limited_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [LIMIT_W-1:0]        lim;
   logic signed [PROD_W-1:0]  lim_w;
   logic signed [SUM_W-1:0]   lim_s;
   logic signed [DATA_W-1:0]  integ_now;
   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x[PROD_W-1:DATA_W-1] == '0 || x[PROD_W-1:DATA_W-1] == '1) begin
         r = x[DATA_W-1:0];
      end else if (x[PROD_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] clamp_lim(input logic signed [PROD_W-1:0] x,
                                                         input logic signed [PROD_W-1:0] l);
      logic signed [DATA_W-1:0] r;
      if (x > l) begin
         r = l[DATA_W-1:0];
      end else if (x < -l) begin
         r = DATA_W'(-l);
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [ACC_W-1:0] to_accum(input logic signed [DATA_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = ACC_W'(v);
      return r <<< INTEG_FRAC_BITS;
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0]   s;
      logic signed [ACC_W-1:0] r;
      s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
      if (s[ACC_W] != s[ACC_W-1]) begin
         r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r = s[ACC_W-1:0];
      end
      return r;
   endfunction

   pidc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_room  (out_room),
      .ctrl      (ctrl)
   );

   assign out_room  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (ctrl.uop == UOP_LATCH);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      lim       = (out_limit_ff < y_max_ff) ? out_limit_ff : y_max_ff;
      lim_w     = signed'(PROD_W'(lim));
      lim_s     = signed'(SUM_W'(lim));
      integ_now = sat32(PROD_W'(accum_ff >>> INTEG_FRAC_BITS));

      case (ctrl.msel)
         MSEL_P: begin
            mul_a = MUL_W'(gain_p_ff);
            mul_b = MUL_W'(req_ff.error_p);
         end
         MSEL_D: begin
            mul_a = MUL_W'(gain_d_ff);
            mul_b = MUL_W'(req_ff.error_d) - MUL_W'(prev_ff);
         end
         MSEL_I: begin
            mul_a = MUL_W'(p_ff);
            mul_b = signed'({1'b0, gain_i_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_in = mul_a * mul_b;

      gain_p_in    = gain_p_ff;
      gain_d_in    = gain_d_ff;
      gain_i_in    = gain_i_ff;
      enable_in    = enable_ff;
      out_limit_in = out_limit_ff;
      y_max_in     = y_max_ff;
      open_loop_in = open_loop_ff;
      pending_in   = pending_ff;
      accum_in     = accum_ff;
      prev_in      = prev_ff;
      held_in      = held_ff;
      frozen_in    = frozen_ff;
      req_in       = req_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      integ_in     = integ_ff;
      sum_in       = sum_ff;
      yc_in        = yc_ff;
      limited_in   = limited_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (ctrl.uop)
         UOP_LATCH: begin
            if (ctrl.fire) begin
               req_in = req_data;
            end
         end
         UOP_PENDING: begin
            if (pending_ff) begin
               if (PROD_W'(integ_now) > lim_w || PROD_W'(integ_now) < -lim_w) begin
                  accum_in = to_accum(clamp_lim(PROD_W'(integ_now), lim_w));
               end
               pending_in = 1'b0;
            end
         end
         UOP_SET: begin
            if (req_ff.integrator_set) begin
               accum_in  = to_accum(clamp_lim(PROD_W'(req_ff.integrator_value), lim_w));
               frozen_in = 1'b1;
            end else begin
               frozen_in = req_ff.integrator_hold;
            end
            p_in    = sat32(mul_ff >>> Q_FRAC_BITS);
            prev_in = req_ff.error_d;
         end
         UOP_INTEG: begin
            integ_in = integ_now;
            d_in     = clamp_lim(mul_ff >>> Q_FRAC_BITS, lim_w);
         end
         UOP_SUM: begin
            sum_in = SUM_W'(p_ff) + SUM_W'(d_ff) + SUM_W'(integ_ff) + SUM_W'(req_ff.feed_forward);
         end
         UOP_UPDATE: begin
            limited_in = 1'b0;
            if (!enable_ff) begin
               accum_in = '0;
               yc_in    = '0;
            end else if (sum_ff >= lim_s) begin
               yc_in      = lim_s[DATA_W-1:0];
               limited_in = 1'b1;
            end else if (sum_ff < -lim_s) begin
               yc_in      = DATA_W'(-lim_s);
               limited_in = 1'b1;
            end else begin
               yc_in = sum_ff[DATA_W-1:0];
               if (!frozen_ff) begin
                  accum_in = sat_add64(accum_ff, ACC_W'(mul_ff >>> I_PROD_SHIFT));
               end else begin
                  accum_in = to_accum(integ_ff);
               end
            end
         end
         UOP_PUBLISH: begin
            if (ctrl.fire) begin
               if (!open_loop_ff) begin
                  held_in = yc_ff;
               end
               rsp_in.control_out    = open_loop_ff ? held_ff : yc_ff;
               rsp_in.integrator_out = integ_ff;
               rsp_in.p_part         = p_ff;
               rsp_in.d_part         = d_ff;
               rsp_in.limited        = limited_ff;
               rsp_valid_in          = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_GAIN_P:    gain_p_in    = csr_wdata;
            CSR_GAIN_D:    gain_d_in    = csr_wdata;
            CSR_GAIN_I:    gain_i_in    = csr_wdata;
            CSR_ENABLE:    enable_in    = csr_wdata[0];
            CSR_OUTPUT_LIMIT: begin
               out_limit_in = csr_wdata[LIMIT_W-1:0];
               pending_in   = 1'b1;
            end
            CSR_Y_MAX: begin
               y_max_in   = csr_wdata[LIMIT_W-1:0];
               pending_in = 1'b1;
            end
            CSR_OPEN_LOOP: open_loop_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= DATA_W'(65536);
         gain_d_ff    <= '0;
         gain_i_ff    <= '0;
         enable_ff    <= 1'b0;
         out_limit_ff <= '0;
         y_max_ff     <= '1;
         open_loop_ff <= 1'b0;
         pending_ff   <= 1'b0;
         accum_ff     <= '0;
         prev_ff      <= '0;
         held_ff      <= '0;
         frozen_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_p_ff    <= gain_p_in;
         gain_d_ff    <= gain_d_in;
         gain_i_ff    <= gain_i_in;
         enable_ff    <= enable_in;
         out_limit_ff <= out_limit_in;
         y_max_ff     <= y_max_in;
         open_loop_ff <= open_loop_in;
         pending_ff   <= pending_in;
         accum_ff     <= accum_in;
         prev_ff      <= prev_in;
         held_ff      <= held_in;
         frozen_ff    <= frozen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      mul_ff     <= mul_in;
      p_ff       <= p_in;
      d_ff       <= d_in;
      integ_ff   <= integ_in;
      sum_ff     <= sum_in;
      yc_ff      <= yc_in;
      limited_ff <= limited_in;
      rsp_ff     <= rsp_in;
   end

   // A published result must appear on the output in the next cycle.
   `PIDC_ASSERT_NEXT(a_publish_shows, (ctrl.uop == UOP_PUBLISH) && ctrl.fire, rsp_valid_ff, "published beat not shown")
   // A result may only be published when the output register is free.
   `PIDC_ASSERT_IMPL(a_publish_room, (ctrl.uop == UOP_PUBLISH) && ctrl.fire, !rsp_valid_ff || rsp_ready, "result beat overwritten")
   // A taken request beat starts the microprogram at the limit step.
   `PIDC_ASSERT_NEXT(a_accept_start, req_valid && req_ready, ctrl.uop == UOP_PENDING, "sequencer did not start")

endmodule

@@ rtl/pidc_seq.sv @@
// ----------------------------------------------------------------------------
// PID controller step: microcode sequencer
// Step counter and control store; each step issues one control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidc_seq
   import pidc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     out_room,
   output ctrl_type ctrl
);

   typedef struct packed {
      uop_type  uop;
      msel_type msel;
      cond_type cond;
      logic     jump;
      step_type target;
   } ucode_type;

   step_type  pc_ff;
   step_type  pc_in;
   ucode_type word;
   logic      fire;

   function automatic ucode_type ucode(input step_type pc);
      ucode_type w;
      w = '{uop: UOP_LATCH, msel: MSEL_NONE, cond: COND_REQ, jump: 1'b0, target: '0};
      case (pc)
         step_type'(0): w = '{uop: UOP_LATCH,   msel: MSEL_NONE, cond: COND_REQ,
                              jump: 1'b0, target: '0};
         step_type'(1): w = '{uop: UOP_PENDING, msel: MSEL_P,    cond: COND_NONE,
                              jump: 1'b0, target: '0};
         step_type'(2): w = '{uop: UOP_SET,     msel: MSEL_D,    cond: COND_NONE,
                              jump: 1'b0, target: '0};
         step_type'(3): w = '{uop: UOP_INTEG,   msel: MSEL_I,    cond: COND_NONE,
                              jump: 1'b0, target: '0};
         step_type'(4): w = '{uop: UOP_SUM,     msel: MSEL_I,    cond: COND_NONE,
                              jump: 1'b0, target: '0};
         step_type'(5): w = '{uop: UOP_UPDATE,  msel: MSEL_NONE, cond: COND_NONE,
                              jump: 1'b0, target: '0};
         step_type'(6): w = '{uop: UOP_PUBLISH, msel: MSEL_NONE, cond: COND_ROOM,
                              jump: 1'b1, target: '0};
         default: w = '{uop: UOP_LATCH, msel: MSEL_NONE, cond: COND_NONE,
                        jump: 1'b1, target: '0};
      endcase
      return w;
   endfunction

   always_comb begin
      word = ucode(pc_ff);
      case (word.cond)
         COND_REQ:  fire = req_valid;
         COND_ROOM: fire = out_room;
         default:   fire = 1'b1;
      endcase
      if (!fire) begin
         pc_in = pc_ff;
      end else if (word.jump) begin
         pc_in = word.target;
      end else begin
         pc_in = step_type'(pc_ff + 1'b1);
      end
      ctrl.uop  = word.uop;
      ctrl.msel = word.msel;
      ctrl.fire = fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
